/* rtl/tcge_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the text cursor glyph expander
// no dependencies

package tcge_pkg;

	localparam int FONT_BYTES  = 1280;
	localparam int FONT_AW     = 11;
	localparam int MAX_SCALE   = 8;
	localparam int GLYPH_COLS  = 5;
	localparam int CELL_COLS   = 6;
	localparam int GLYPH_ROWS  = 8;

	localparam logic [7:0] CLASSIC_SHIFT_FROM = 8'd176;
	localparam logic [7:0] CODE_NEWLINE       = 8'd10;
	localparam logic [7:0] CODE_CR            = 8'd13;

	localparam logic [1:0] CMD_WRITE_CHAR = 2'd0;
	localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
	localparam logic [1:0] CMD_LOAD_FONT  = 2'd2;

	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_TEXT_SCALE    = 3'd2;
	localparam logic [2:0] REG_TEXT_COLOR    = 3'd3;
	localparam logic [2:0] REG_BG_COLOR      = 3'd4;
	localparam logic [2:0] REG_WRAP_ENABLE   = 3'd5;
	localparam logic [2:0] REG_CP437_MODE    = 3'd6;

	typedef struct packed {
		logic [15:0]                      x;
		logic [15:0]                      y;
		logic [GLYPH_COLS-1:0][7:0]       cols;
		logic [3:0]                       scale;
		logic [15:0]                      fg;
		logic [15:0]                      bg;
	} glyph_job_t;

	typedef struct packed {
		logic ready;
		logic busy;
	} gen_status_t;

endpackage

/* rtl/tcge_font_ram.sv */
`timescale 1ns / 1ps
// glyph column store, one write port and one registered read port
// uses tcge_pkg for depth and address width

module tcge_font_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [tcge_pkg::FONT_AW-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic                        re,
	input  logic [tcge_pkg::FONT_AW-1:0] raddr,
	output logic [7:0]                  rdata
);

	logic [7:0] mem [tcge_pkg::FONT_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/tcge_row_gen.sv */
`timescale 1ns / 1ps
// expands one latched glyph into pixel rows with an output register
// uses tcge_pkg for the job and status types

module tcge_row_gen (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tcge_pkg::glyph_job_t job,
	output tcge_pkg::gen_status_t status,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// window_x, window_y, pixel_row, cell0..cell5 colors, zero fill
	output logic [135:0]         m_tdata,
	output logic                 m_tlast
);

	tcge_pkg::glyph_job_t job_q;
	logic                 busy_q;
	logic [5:0]           r_q;
	logic [2:0]           rep_q;
	logic [2:0]           gy_q;
	logic                 m_tvalid_q;
	logic [135:0]         m_tdata_q;
	logic                 m_tlast_q;

	logic [6:0]           rows_m1;
	logic                 last;
	logic                 load;
	logic [15:0]          cell_color [tcge_pkg::GLYPH_COLS];

	assign rows_m1 = {job_q.scale, 3'b000} - 7'd1;
	assign last    = ({1'b0, r_q} == rows_m1);
	assign load    = busy_q && (!m_tvalid_q || m_tready);

	always_comb begin
		for (int i = 0; i < tcge_pkg::GLYPH_COLS; i++) begin
			cell_color[i] = job_q.cols[i][gy_q] ? job_q.fg : job_q.bg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			r_q        <= '0;
			rep_q      <= '0;
			gy_q       <= '0;
		end else begin
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				r_q    <= '0;
				rep_q  <= '0;
				gy_q   <= '0;
			end else if (load) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				r_q <= r_q + 6'd1;
				if ({1'b0, rep_q} == job_q.scale - 4'd1) begin
					rep_q <= '0;
					gy_q  <= gy_q + 3'd1;
				end else begin
					rep_q <= rep_q + 3'd1;
				end
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			job_q <= job;
		end
		if (load) begin
			m_tdata_q <= {2'b00, job_q.bg, cell_color[4], cell_color[3], cell_color[2],
				cell_color[1], cell_color[0], r_q, job_q.y, job_q.x};
			m_tlast_q <= last;
		end
	end

	assign status.ready = !busy_q;
	assign status.busy  = busy_q;
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;
	assign m_tlast      = m_tlast_q;

endmodule

/* rtl/text_cursor_glyph_expander_unit.sv */
`timescale 1ns / 1ps
// top level: cursor, command sequencer, font store and row expander
// uses tcge_pkg, tcge_font_ram and tcge_row_gen

// Takes write-character, set-cursor and load-font-byte commands and emits the pixel
// rows of each drawn 5x8 glyph, 8*scale rows per glyph, one row per output transfer.
// Set cursor, font loads, newline and carriage return complete as they are accepted.
// A drawn or clipped character passes the wrap test as it is accepted, then the clip
// test; a drawn one then reads its five column bytes through the single read port of
// the font store and hands them to the row expander. The rows then leave at one per
// cycle while the output is not stalled, and the next character is already being
// taken and read meanwhile; a stalled output holds the next glyph in the hand-over
// state, blocking the input. Font bytes must be loaded before they are drawn.

module text_cursor_glyph_expander_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// char_code, new_x, new_y, font_index, font_byte, zero fill
	input  logic [63:0]  s_tdata,
	// command
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// window_x, window_y, pixel_row, cell0..cell5 colors, zero fill
	output logic [135:0] m_tdata,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_CLIP, ST_READ, ST_EMIT} state_t;

	state_t      state_q;
	logic [15:0] screen_width_q;
	logic [15:0] screen_height_q;
	logic [3:0]  text_scale_q;
	logic [15:0] text_color_q;
	logic [15:0] bg_color_q;
	logic        wrap_enable_q;
	logic        cp437_mode_q;

	logic [15:0] cursor_col_q;
	logic [15:0] cursor_row_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [7:0]  code_q;
	logic [10:0] base_q;
	logic [2:0]  rd_cnt_q;
	logic [tcge_pkg::GLYPH_COLS-1:0][7:0] cols_q;

	logic [7:0]  in_code;
	logic [15:0] in_x;
	logic [15:0] in_y;
	logic [10:0] in_index;
	logic [7:0]  in_byte;
	logic        accept;

	logic [3:0]  scale;
	logic [5:0]  adv;
	logic [6:0]  line_h;
	logic        wrap;
	logic [15:0] row_down;

	logic        ram_we;
	logic        ram_re;
	logic [10:0] ram_raddr;
	logic [7:0]  ram_rdata;

	logic                  gen_start;
	tcge_pkg::glyph_job_t  job;
	tcge_pkg::gen_status_t gen_status;

	assign in_code  = s_tdata[7:0];
	assign in_x     = s_tdata[23:8];
	assign in_y     = s_tdata[39:24];
	assign in_index = s_tdata[50:40];
	assign in_byte  = s_tdata[58:51];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (text_scale_q == 4'd0) begin
			scale = 4'd1;
		end else if (text_scale_q > 4'(tcge_pkg::MAX_SCALE)) begin
			scale = 4'(tcge_pkg::MAX_SCALE);
		end else begin
			scale = text_scale_q;
		end
	end

	assign adv      = {2'b00, scale} * 6'(tcge_pkg::CELL_COLS);
	assign line_h   = {scale, 3'b000};
	assign row_down = cursor_row_q + {9'd0, line_h};
	assign wrap     = wrap_enable_q &&
		(({1'b0, cursor_col_q} + {11'd0, adv}) >= {1'b0, screen_width_q});

	assign ram_we    = accept && (s_tuser == tcge_pkg::CMD_LOAD_FONT) &&
		(in_index < 11'(tcge_pkg::FONT_BYTES));
	assign ram_re    = (state_q == ST_READ) && (rd_cnt_q < 3'(tcge_pkg::GLYPH_COLS));
	assign ram_raddr = base_q + {8'd0, rd_cnt_q};

	tcge_font_ram u_font_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_index),
		.wdata (in_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign gen_start = (state_q == ST_EMIT);
	assign job.x     = x_q;
	assign job.y     = y_q;
	assign job.cols  = cols_q;
	assign job.scale = scale;
	assign job.fg    = text_color_q;
	assign job.bg    = bg_color_q;

	tcge_row_gen u_row_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (gen_start),
		.job      (job),
		.status   (gen_status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 16'd240;
			screen_height_q <= 16'd320;
			text_scale_q    <= 4'd1;
			text_color_q    <= 16'd63488;
			bg_color_q      <= 16'd65535;
			wrap_enable_q   <= 1'b1;
			cp437_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tcge_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				tcge_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				tcge_pkg::REG_TEXT_SCALE:    text_scale_q    <= cfg_data[3:0];
				tcge_pkg::REG_TEXT_COLOR:    text_color_q    <= cfg_data;
				tcge_pkg::REG_BG_COLOR:      bg_color_q      <= cfg_data;
				tcge_pkg::REG_WRAP_ENABLE:   wrap_enable_q   <= cfg_data[0];
				tcge_pkg::REG_CP437_MODE:    cp437_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// command sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			rd_cnt_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							tcge_pkg::CMD_SET_CURSOR: begin
								cursor_col_q <= in_x;
								cursor_row_q <= in_y;
							end
							tcge_pkg::CMD_WRITE_CHAR: begin
								if (in_code == tcge_pkg::CODE_NEWLINE) begin
									cursor_col_q <= '0;
									cursor_row_q <= row_down;
								end else if (in_code == tcge_pkg::CODE_CR) begin
									cursor_col_q <= '0;
								end else begin
									if (wrap) begin
										cursor_col_q <= {10'd0, adv};
										cursor_row_q <= row_down;
									end else begin
										cursor_col_q <= cursor_col_q + {10'd0, adv};
									end
									state_q <= ST_CLIP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CLIP: begin
					if ((x_q >= screen_width_q) || (y_q >= screen_height_q)) begin
						state_q <= ST_IDLE;
					end else begin
						rd_cnt_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'(tcge_pkg::GLYPH_COLS)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (gen_status.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// glyph payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= wrap ? 16'd0 : cursor_col_q;
			y_q <= wrap ? row_down : cursor_row_q;
			if (!cp437_mode_q && (in_code >= tcge_pkg::CLASSIC_SHIFT_FROM)) begin
				code_q <= in_code + 8'd1;
			end else begin
				code_q <= in_code;
			end
		end
		if (state_q == ST_CLIP) begin
			base_q <= {1'b0, code_q, 2'b00} + {3'd0, code_q};
		end
		if ((state_q == ST_READ) && (rd_cnt_q != 3'd0)) begin
			cols_q[rd_cnt_q - 3'd1] <= ram_rdata;
		end
	end

	// the read counter never exceeds the number of column bytes
	a_rd_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (rd_cnt_q <= 3'(tcge_pkg::GLYPH_COLS)))
		else $error("font read counter out of range");

	// a handed-over glyph always leaves the expander busy
	a_gen_takes_job: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_start && gen_status.ready) |=> gen_status.busy)
		else $error("row expander dropped a glyph");

	// the clip test either ends the item or starts the font reads
	a_clip_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLIP) |=>
			((state_q == ST_IDLE) || (state_q == ST_READ && rd_cnt_q == 3'd0)))
		else $error("bad exit from clip test");

	// font loads only happen while the sequencer is free
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("font store write during glyph read");

endmodule

/* tb/sv/text_cursor_glyph_expander_unit_test.sv */
`timescale 1ns / 1ps
// self-checking test of text_cursor_glyph_expander_unit: directed table, then random phases
// uses tcge_pkg and the unit; predicts cursor, font store and glyph rows, checks each row

module text_cursor_glyph_expander_unit_test;
	import tcge_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_OPS = 35;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [7:0]        code;
		logic [15:0]       nx;
		logic [15:0]       ny;
		logic [10:0]       fidx;
		logic [7:0]        fbyte;
		logic signed [7:0] want_rows;
	} text_op_t;

	typedef struct packed {
		logic              last;
		logic [5:0][15:0]  cells;
		logic [5:0]        prow;
		logic [15:0]       wy;
		logic [15:0]       wx;
	} glyph_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [63:0]   s_tdata = '0;
	logic [1:0]    s_tuser = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [135:0]  m_tdata;
	logic          m_tlast;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_index = '0;
	logic [15:0]   cfg_data = '0;

	// predictor state
	logic [15:0] cur_col, cur_row;
	logic [7:0]  font_img [FONT_BYTES];
	logic [15:0] scr_w, scr_h, fg_color, bg_color;
	logic [3:0]  txt_scale;
	logic        wrap_on, cp437_on;

	glyph_row_t  pending_rows [$];
	logic [7:0]  stocked_glyphs [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	logic        steady = 1'b0;

	text_cursor_glyph_expander_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	text_op_t directed_ops [0:24] = '{
		'{CMD_WRITE_CHAR, 8'd65,        16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_WRITE_CHAR, 8'd127,       16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_WRITE_CHAR, CODE_CR,      16'd0,     16'd0,     11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, CODE_NEWLINE, 16'd0,     16'd0,     11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, 8'd128,       16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_WRITE_CHAR, 8'd175,       16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_WRITE_CHAR, 8'd176,       16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_WRITE_CHAR, 8'd254,       16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_WRITE_CHAR, 8'd255,       16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_SET_CURSOR, 8'd0,         16'd234,   16'd0,     11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, 8'd65,        16'd0,     16'd0,     11'd0,    8'd0,  -8'sd1},
		'{CMD_SET_CURSOR, 8'd0,         16'd233,   16'd0,     11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, 8'd65,        16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_SET_CURSOR, 8'd0,         16'd0,     16'd319,   11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, 8'd0,         16'd0,     16'd0,     11'd0,    8'd0,   8'sd8},
		'{CMD_SET_CURSOR, 8'd0,         16'd0,     16'd320,   11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, 8'd65,        16'd0,     16'd0,     11'd0,    8'd0,   8'sd0},
		'{CMD_SET_CURSOR, 8'd0,         16'hFFFF,  16'hFFFF,  11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, 8'd65,        16'd0,     16'd0,     11'd0,    8'd0,  -8'sd1},
		'{CMD_SET_CURSOR, 8'd0,         16'd0,     16'd65528, 11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, CODE_NEWLINE, 16'd0,     16'd0,     11'd0,    8'd0,   8'sd0},
		'{CMD_WRITE_CHAR, 8'd65,        16'd0,     16'd0,     11'd0,    8'd0,  -8'sd1},
		'{CMD_UNUSED,     8'hFF,        16'hFFFF,  16'hFFFF,  11'h7FF,  8'hFF,  8'sd0},
		'{CMD_LOAD_FONT,  8'd0,         16'd0,     16'd0,     11'd2047, 8'hFF,  8'sd0},
		'{CMD_LOAD_FONT,  8'd0,         16'd0,     16'd0,     11'd1280, 8'hAA,  8'sd0}
	};

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s expected %h actual %h", name, want, got));
	endtask

	// updates the cursor and font copy, queues the rows the op draws
	task automatic render_op(input text_op_t op, output int produced);
		int unsigned sc, line_h, adv, gy;
		logic [15:0] x, y;
		logic [7:0]  glyph;
		logic [7:0]  cols [GLYPH_COLS];
		glyph_row_t  row;
		produced = 0;
		sc = (txt_scale == 0) ? 1 : ((txt_scale > MAX_SCALE) ? MAX_SCALE : txt_scale);
		line_h = GLYPH_ROWS * sc;
		adv = CELL_COLS * sc;
		case (op.cmd)
			CMD_SET_CURSOR: begin
				cur_col = op.nx;
				cur_row = op.ny;
			end
			CMD_LOAD_FONT: begin
				if (op.fidx < FONT_BYTES)
					font_img[op.fidx] = op.fbyte;
			end
			CMD_WRITE_CHAR: begin
				if (op.code == CODE_NEWLINE) begin
					cur_row = cur_row + 16'(line_h);
					cur_col = '0;
				end else if (op.code == CODE_CR) begin
					cur_col = '0;
				end else begin
					if (wrap_on && (int'(cur_col) + int'(adv) >= int'(scr_w))) begin
						cur_col = '0;
						cur_row = cur_row + 16'(line_h);
					end
					x = cur_col;
					y = cur_row;
					cur_col = cur_col + 16'(adv);
					if (x < scr_w && y < scr_h) begin
						glyph = op.code;
						if (!cp437_on && glyph >= CLASSIC_SHIFT_FROM)
							glyph = glyph + 8'd1;
						for (int i = 0; i < GLYPH_COLS; i++)
							cols[i] = font_img[int'(glyph) * GLYPH_COLS + i];
						for (int r = 0; r < int'(line_h); r++) begin
							gy = r / sc;
							row.wx = x;
							row.wy = y;
							row.prow = 6'(r);
							for (int i = 0; i < GLYPH_COLS; i++)
								row.cells[i] = cols[i][gy] ? fg_color : bg_color;
							row.cells[5] = bg_color;
							row.last = (r == int'(line_h) - 1);
							pending_rows.push_back(row);
						end
						produced = line_h;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_op(input text_op_t op);
		int produced;
		while (!steady && $urandom_range(0, 99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op.cmd;
		s_tdata <= {5'd0, op.fbyte, op.fidx, op.ny, op.nx, op.code};
		do @(posedge clk); while (!s_tready);
		render_op(op, produced);
		if (op.want_rows >= 0 && produced != op.want_rows)
			note_mismatch($sformatf("command %0d code %0d: table says %0d rows, model %0d",
				op.cmd, op.code, op.want_rows, produced));
	endtask

	function automatic text_op_t noise_op();
		text_op_t op;
		op.cmd = 2'($urandom_range(0, 3));
		op.code = 8'($urandom);
		op.nx = 16'($urandom);
		op.ny = 16'($urandom);
		op.fidx = 11'($urandom);
		op.fbyte = 8'($urandom);
		op.want_rows = -8'sd1;
		return op;
	endfunction

	task automatic load_glyph(input logic [7:0] g);
		text_op_t op;
		for (int i = 0; i < GLYPH_COLS; i++) begin
			op = noise_op();
			op.cmd = CMD_LOAD_FONT;
			op.fidx = 11'(int'(g) * GLYPH_COLS + i);
			push_op(op);
		end
		stocked_glyphs.push_back(g);
	endtask

	// a code that draws glyph g under the current charset (175 in place of 176 in classic mode)
	function automatic logic [7:0] code_for_glyph(input logic [7:0] g);
		if (cp437_on)
			return g;
		if (g == 8'd0 && $urandom_range(0, 1))
			return 8'd255;
		// glyph 176 is out of reach in classic mode
		if (g == CLASSIC_SHIFT_FROM)
			return CLASSIC_SHIFT_FROM - 8'd1;
		if (g > CLASSIC_SHIFT_FROM)
			return g - 8'd1;
		return g;
	endfunction

	task automatic drain(input int settle);
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SCREEN_WIDTH:  scr_w = val;
			REG_SCREEN_HEIGHT: scr_h = val;
			REG_TEXT_SCALE:    txt_scale = val[3:0];
			REG_TEXT_COLOR:    fg_color = val;
			REG_BG_COLOR:      bg_color = val;
			REG_WRAP_ENABLE:   wrap_on = val[0];
			REG_CP437_MODE:    cp437_on = val[0];
			default: ;
		endcase
	endtask

	task automatic set_display(input logic [15:0] w, input logic [15:0] h, input logic [3:0] s,
			input logic [15:0] fg, input logic [15:0] bg, input logic wrap, input logic cp);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_TEXT_SCALE, {12'd0, s});
		write_reg(REG_TEXT_COLOR, fg);
		write_reg(REG_BG_COLOR, bg);
		write_reg(REG_WRAP_ENABLE, {15'd0, wrap});
		write_reg(REG_CP437_MODE, {15'd0, cp});
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int n_ops);
		text_op_t op;
		int counted, pick, sub;
		counted = 0;
		while (counted < n_ops) begin
			op = noise_op();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				op.cmd = CMD_WRITE_CHAR;
				op.code = code_for_glyph(
					stocked_glyphs[$urandom_range(0, stocked_glyphs.size() - 1)]);
				push_op(op);
				counted++;
			end else if (pick < 62) begin
				op.cmd = CMD_WRITE_CHAR;
				op.code = $urandom_range(0, 1) ? CODE_NEWLINE : CODE_CR;
				push_op(op);
				counted++;
			end else if (pick < 72) begin
				op.cmd = CMD_SET_CURSOR;
				sub = $urandom_range(0, 9);
				if (sub < 8) begin
					op.ny = 16'($urandom_range(0, int'(scr_h) - 1));
					if (sub < 6 || scr_w <= 64)
						op.nx = 16'($urandom_range(0, int'(scr_w) - 1));
					else
						op.nx = scr_w - 16'($urandom_range(1, 64));
				end
				push_op(op);
				counted++;
			end else if (pick < 82) begin
				load_glyph(8'($urandom));
				counted += GLYPH_COLS;
			end else if (pick < 90) begin
				op.cmd = CMD_LOAD_FONT;
				push_op(op);
				if (op.fidx < FONT_BYTES)
					counted++;
			end else begin
				op.cmd = CMD_UNUSED;
				push_op(op);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= steady || ($urandom_range(0, 99) >= 29);
	end

	always @(posedge clk) begin : row_monitor
		glyph_row_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.wx = m_tdata[15:0];
				got.wy = m_tdata[31:16];
				got.prow = m_tdata[37:32];
				for (int c = 0; c < 6; c++)
					got.cells[c] = m_tdata[38 + 16 * c +: 16];
				got.last = m_tlast;
				if (pending_rows.size() == 0) begin
					note_mismatch($sformatf("row transfer with nothing pending: x %h y %h row %0d",
						got.wx, got.wy, got.prow));
				end else begin
					want = pending_rows.pop_front();
					check_field("window_x", got.wx, want.wx);
					check_field("window_y", got.wy, want.wy);
					check_field("pixel_row", 16'(got.prow), 16'(want.prow));
					for (int c = 0; c < 6; c++)
						check_field($sformatf("cell%0d_color", c), got.cells[c], want.cells[c]);
					check_field("last_row", 16'(got.last), 16'(want.last));
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		cur_col = '0;
		cur_row = '0;
		scr_w = 16'd240;
		scr_h = 16'd320;
		txt_scale = 4'd1;
		fg_color = 16'd63488;
		bg_color = 16'd65535;
		wrap_on = 1'b1;
		cp437_on = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// glyphs used by the directed table, plus 176 for the cp437 phases
		load_glyph(8'd0);
		load_glyph(8'd65);
		load_glyph(8'd127);
		load_glyph(8'd128);
		load_glyph(8'd175);
		load_glyph(8'd176);
		load_glyph(8'd177);
		load_glyph(8'd255);

		foreach (directed_ops[k])
			push_op(directed_ops[k]);

		for (int p = 0; p < 5; p++) begin
			drain(16);
			case (p)
				0: set_display(16'hFFFF, 16'hFFFF, 4'd8, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
				1: set_display(16'd1, 16'd1, 4'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
				2: set_display(16'($urandom_range(48, 400)), 16'($urandom_range(48, 400)),
					4'($urandom_range(1, 4)), 16'($urandom), 16'($urandom), 1'b1, 1'b0);
				3: set_display(16'd200, 16'd120, 4'd15, 16'($urandom), 16'($urandom),
					1'b1, 1'b1);
				default: set_display(16'($urandom_range(100, 1000)),
					16'($urandom_range(100, 600)), 4'($urandom_range(2, 3)),
					16'($urandom), 16'($urandom), 1'b0, 1'b0);
			endcase
			// one phase runs with the input always valid and the output always ready
			steady = (p == 2);
			random_phase(PHASE_OPS);
		end
		steady = 1'b0;

		drain(100);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
